// ===== sv/prsd_pkg.sv =====
// Shared types, constants and helper functions for the palette run-length sprite decoder.
`timescale 1ns / 1ps

package prsd_pkg;

	// Palette depth and the width of the frame pixel counters.
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int CNT_W       = 24;

	// Fixed field widths of the stream words.
	localparam int IDX_W   = 8;
	localparam int COLOR_W = 24;
	localparam int CODE_W  = 8;
	localparam int FRAME_W = 24;
	localparam int RUN_W   = 15;
	localparam int PIX_W   = 32;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DECODE_FORMAT = 2'd0;
	localparam logic [1:0] CFG_PIXEL_LAYOUT  = 2'd1;
	localparam logic [1:0] CFG_KEY_COLOR     = 2'd2;

	// Output pixel layouts; the unused code behaves as RGB.
	localparam logic [1:0] LAYOUT_RGB  = 2'd0;
	localparam logic [1:0] LAYOUT_RGBA = 2'd1;
	localparam logic [1:0] LAYOUT_BGRA = 2'd2;

	// Word actions carried on the input tuser.
	localparam logic [1:0] ACT_PAL_WRITE = 2'd0;
	localparam logic [1:0] ACT_DATA      = 2'd1;
	localparam logic [1:0] ACT_FRAME     = 2'd2;

	// Code byte constants.
	localparam logic [7:0] RUN_BASE      = 8'h80;
	localparam logic [7:0] HIGH_ALPHA    = 8'h40;
	localparam logic [7:0] HIGH_PLAIN    = 8'h00;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR   = 8'h00;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_CODE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LIT   = 2'd2,
		PH_INDEX = 2'd3
	} phase_t;

	// Kind of result leaving the parser.
	typedef enum logic [1:0] {
		RES_NONE   = 2'd0,
		RES_TRANSP = 2'd1,
		RES_LIT    = 2'd2,
		RES_ERR    = 2'd3
	} res_kind_t;

	// Parser result handed to the output stage.
	typedef struct packed {
		res_kind_t          kind;
		logic [RUN_W-1:0]   run;
		logic [7:0]         alpha;
	} result_t;

	// Palette write and read request.
	typedef struct packed {
		logic               wr;
		logic [IDX_W-1:0]   wr_index;
		logic [COLOR_W-1:0] wr_color;
		logic               rd;
		logic [IDX_W-1:0]   rd_index;
	} pal_req_t;

	// Arrange a color and alpha in the selected byte order.
	function automatic logic [PIX_W-1:0] pack_pixel(input logic [COLOR_W-1:0] rgb,
			input logic [7:0] alpha, input logic [1:0] layout);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [PIX_W-1:0] word;
		r = rgb[7:0];
		g = rgb[15:8];
		b = rgb[23:16];
		case (layout)
			LAYOUT_RGBA: word = {alpha, b, g, r};
			LAYOUT_BGRA: word = {alpha, r, g, b};
			default:     word = {8'h00, b, g, r};
		endcase
		return word;
	endfunction

endpackage

// ===== sv/prsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module prsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/prsd_palette.sv =====
// Palette color store: RAM plus per-entry valid bits so unwritten entries read as zero.
`timescale 1ns / 1ps

module prsd_palette (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prsd_pkg::pal_req_t            req,
	output logic [prsd_pkg::COLOR_W-1:0]  color_s2
);

	logic [prsd_pkg::PAL_ENTRIES-1:0]   valid_q;
	logic [prsd_pkg::COLOR_W-1:0]       ram_rdata;
	logic                               wr_in_range;
	logic                               rd_in_range;
	logic                               wr_en;
	logic                               hit_s2;
	logic [prsd_pkg::PAL_AW-1:0]        wr_addr;
	logic [prsd_pkg::PAL_AW-1:0]        rd_addr;

	// Indexes past the table are dropped on write and read as zero.
	assign wr_in_range = ({1'b0, req.wr_index} < (prsd_pkg::IDX_W+1)'(prsd_pkg::PAL_ENTRIES));
	assign rd_in_range = ({1'b0, req.rd_index} < (prsd_pkg::IDX_W+1)'(prsd_pkg::PAL_ENTRIES));
	assign wr_addr     = req.wr_index[prsd_pkg::PAL_AW-1:0];
	assign rd_addr     = req.rd_index[prsd_pkg::PAL_AW-1:0];
	assign wr_en       = req.wr && wr_in_range;

	prsd_ram #(
		.WIDTH(prsd_pkg::COLOR_W),
		.DEPTH(prsd_pkg::PAL_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (req.wr_color),
		.re    (req.rd),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Valid bits are cleared by reset and set by the first write of each entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s2  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (req.rd) begin
				hit_s2 <= rd_in_range && valid_q[rd_addr];
			end
		end
	end

	assign color_s2 = hit_s2 ? ram_rdata : '0;

endmodule

// ===== sv/prsd_parser.sv =====
// Code stream parser: header decode, literal tracking, pixel budget and error halt.
`timescale 1ns / 1ps

module prsd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [1:0]                    action,
	input  logic [prsd_pkg::CODE_W-1:0]   code,
	input  logic [prsd_pkg::FRAME_W-1:0]  frame_pixels,
	input  logic                          decode_format,
	output prsd_pkg::result_t             res_s2
);

	localparam int RW = prsd_pkg::RUN_W;
	localparam int CW = prsd_pkg::CNT_W;

	prsd_pkg::phase_t       phase_q, nxt_phase;
	logic [7:0]             held_q, nxt_held;
	logic [7:0]             left_q, nxt_left;
	logic                   alpha_lit_q, nxt_alpha_lit;
	logic [CW-1:0]          used_q, nxt_used;
	logic [CW-1:0]          budget_q, nxt_budget;
	logic                   halted_q, nxt_halted;
	prsd_pkg::result_t      res;

	logic                   sel_run;
	logic                   sel_grp;
	logic                   sel_lit;
	logic                   bad;
	logic [RW-1:0]          run_n;
	logic [7:0]             grp_n;
	logic                   grp_alpha;
	logic [7:0]             lit_alpha;
	logic [RW-1:0]          n_eff;
	logic [CW:0]            sum;
	logic                   over;

	// Decode one word against the current phase, then apply the budget check.
	always_comb begin
		nxt_phase     = phase_q;
		nxt_held      = held_q;
		nxt_left      = left_q;
		nxt_alpha_lit = alpha_lit_q;
		nxt_used      = used_q;
		nxt_budget    = budget_q;
		nxt_halted    = halted_q;
		res.kind      = prsd_pkg::RES_NONE;
		res.run       = '0;
		res.alpha     = prsd_pkg::ALPHA_CLEAR;
		sel_run       = 1'b0;
		sel_grp       = 1'b0;
		sel_lit       = 1'b0;
		bad           = 1'b0;
		run_n         = '0;
		grp_n         = '0;
		grp_alpha     = 1'b0;
		lit_alpha     = prsd_pkg::ALPHA_OPAQUE;

		if (in_valid) begin
			case (action)
				prsd_pkg::ACT_FRAME: begin
					nxt_budget    = CW'(frame_pixels);
					nxt_used      = '0;
					nxt_phase     = prsd_pkg::PH_CODE;
					nxt_held      = '0;
					nxt_left      = '0;
					nxt_alpha_lit = 1'b0;
					nxt_halted    = 1'b0;
				end
				prsd_pkg::ACT_DATA: begin
					if (!halted_q) begin
						if (phase_q == prsd_pkg::PH_LIT) begin
							if (alpha_lit_q) begin
								nxt_held  = code;
								nxt_phase = prsd_pkg::PH_INDEX;
							end else begin
								sel_lit = 1'b1;
							end
						end else if (phase_q == prsd_pkg::PH_INDEX) begin
							sel_lit   = 1'b1;
							lit_alpha = held_q;
						end else if (!decode_format) begin
							// Byte codes: above the run base is a transparent run.
							if (code > prsd_pkg::RUN_BASE) begin
								sel_run = 1'b1;
								run_n   = {8'd0, code[6:0]};
							end else begin
								sel_grp = 1'b1;
								grp_n   = code;
							end
						end else if (phase_q == prsd_pkg::PH_CODE) begin
							nxt_held  = code;
							nxt_phase = prsd_pkg::PH_HIGH;
						end else if (code[7]) begin
							sel_run = 1'b1;
							run_n   = {code[6:0], held_q};
						end else if (code == prsd_pkg::HIGH_ALPHA) begin
							sel_grp   = 1'b1;
							grp_n     = held_q;
							grp_alpha = 1'b1;
						end else if (code == prsd_pkg::HIGH_PLAIN) begin
							sel_grp = 1'b1;
							grp_n   = held_q;
						end else begin
							bad = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// One adder serves the budget check and the pixel count update.
		if (sel_run) begin
			n_eff = run_n;
		end else if (sel_grp) begin
			n_eff = RW'(grp_n);
		end else if (sel_lit) begin
			n_eff = RW'(1);
		end else begin
			n_eff = '0;
		end
		sum  = {1'b0, used_q} + (CW+1)'(n_eff);
		over = sum > {1'b0, budget_q};

		// Runs and literal groups are checked against the budget when announced.
		if (sel_run || sel_grp) begin
			nxt_phase = prsd_pkg::PH_CODE;
			if (n_eff != '0) begin
				if (over) begin
					bad = 1'b1;
				end else if (sel_run) begin
					nxt_used  = sum[CW-1:0];
					res.kind  = prsd_pkg::RES_TRANSP;
					res.run   = run_n;
				end else begin
					nxt_left      = grp_n;
					nxt_alpha_lit = grp_alpha;
					nxt_phase     = prsd_pkg::PH_LIT;
				end
			end
		end

		// A literal pixel consumes one entry of the announced group.
		if (sel_lit) begin
			nxt_used  = sum[CW-1:0];
			nxt_left  = left_q - 8'd1;
			nxt_phase = (left_q == 8'd1) ? prsd_pkg::PH_CODE : prsd_pkg::PH_LIT;
			res.kind  = prsd_pkg::RES_LIT;
			res.run   = RW'(1);
			res.alpha = lit_alpha;
		end

		// Bad code or overrun halts the frame and reports an error word.
		if (bad) begin
			nxt_halted = 1'b1;
			nxt_phase  = prsd_pkg::PH_CODE;
			nxt_left   = '0;
			res.kind   = prsd_pkg::RES_ERR;
			res.run    = '0;
			res.alpha  = prsd_pkg::ALPHA_CLEAR;
		end
	end

	// Parser state and the stage-two result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= prsd_pkg::PH_CODE;
			held_q      <= '0;
			left_q      <= '0;
			alpha_lit_q <= 1'b0;
			used_q      <= '0;
			budget_q    <= '0;
			halted_q    <= 1'b0;
			res_s2      <= '{kind: prsd_pkg::RES_NONE, run: '0, alpha: prsd_pkg::ALPHA_CLEAR};
		end else if (en) begin
			phase_q     <= nxt_phase;
			held_q      <= nxt_held;
			left_q      <= nxt_left;
			alpha_lit_q <= nxt_alpha_lit;
			used_q      <= nxt_used;
			budget_q    <= nxt_budget;
			halted_q    <= nxt_halted;
			res_s2      <= res;
		end
	end

endmodule

// ===== sv/palette_rle_sprite_decoder.sv =====
// Top level of the palette run-length sprite decoder: input, parser, palette and output stages.
// An accepted word passes the input register and the parser and palette stage into the output register on m_tvalid.
// Throughput: one input word per cycle; the parser state and the palette read port each
// take one word per cycle, and back-to-back words flow while the output side is ready.
// Every word gives zero or one result; a stall on the output side holds all three stages.
// Reset (arst_n low) clears the parser, the pixel budget, the palette valid bits and config.
`timescale 1ns / 1ps

module palette_rle_sprite_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pal_index[7:0], pal_color[31:8], code_byte[39:32], frame_pixels[63:40]
	input  logic [1:0]  s_tuser,   // action[1:0]
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pixel_word[31:0], run_length[46:32], zero pad [47]
	output logic        m_tuser,   // bad_stream[0]
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);

	logic                                en;
	logic                                v_s1;
	logic [1:0]                          action_s1;
	logic [prsd_pkg::IDX_W-1:0]          pal_index_s1;
	logic [prsd_pkg::COLOR_W-1:0]        pal_color_s1;
	logic [prsd_pkg::CODE_W-1:0]         code_s1;
	logic [prsd_pkg::FRAME_W-1:0]        frame_s1;
	logic                                fmt_q;
	logic [1:0]                          layout_q;
	logic [prsd_pkg::COLOR_W-1:0]        key_q;
	prsd_pkg::pal_req_t                  pal_req;
	prsd_pkg::result_t                   res_s2;
	logic [prsd_pkg::COLOR_W-1:0]        pal_color_s2;
	logic [prsd_pkg::COLOR_W-1:0]        color;
	logic [prsd_pkg::PIX_W-1:0]          word;
	logic                                m_valid_q;
	logic [prsd_pkg::OUT_DATA_W-1:0]     m_data_q;
	logic                                m_bad_q;

	// The pipeline moves whenever the output register is empty or being drained.
	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= 1'b0;
			layout_q <= prsd_pkg::LAYOUT_RGB;
			key_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				prsd_pkg::CFG_DECODE_FORMAT: fmt_q    <= cfg_wdata[0];
				prsd_pkg::CFG_PIXEL_LAYOUT:  layout_q <= cfg_wdata[1:0];
				prsd_pkg::CFG_KEY_COLOR:     key_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1    <= s_tuser;
			pal_index_s1 <= s_tdata[7:0];
			pal_color_s1 <= s_tdata[31:8];
			code_s1      <= s_tdata[39:32];
			frame_s1     <= s_tdata[63:40];
		end
	end

	// Palette writes land from stage one; every data byte reads the palette at its value.
	always_comb begin
		pal_req.wr       = en && v_s1 && (action_s1 == prsd_pkg::ACT_PAL_WRITE);
		pal_req.wr_index = pal_index_s1;
		pal_req.wr_color = pal_color_s1;
		pal_req.rd       = en;
		pal_req.rd_index = code_s1;
	end

	prsd_palette u_palette (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (pal_req),
		.color_s2 (pal_color_s2)
	);

	prsd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (v_s1),
		.action        (action_s1),
		.code          (code_s1),
		.frame_pixels  (frame_s1),
		.decode_format (fmt_q),
		.res_s2        (res_s2)
	);

	// Pixel assembly for the output register.
	assign color = (res_s2.kind == prsd_pkg::RES_TRANSP) ? key_q : pal_color_s2;
	always_comb begin
		if (res_s2.kind == prsd_pkg::RES_ERR) begin
			word = '0;
		end else begin
			word = prsd_pkg::pack_pixel(color, res_s2.alpha, layout_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= (res_s2.kind != prsd_pkg::RES_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= {1'b0, res_s2.run, word};
			m_bad_q  <= (res_s2.kind == prsd_pkg::RES_ERR);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_bad_q;

endmodule

// ===== sv/prsd_checker.sv =====
// Port-level checker for the palette run-length sprite decoder, bound to the top level.
`timescale 1ns / 1ps

module prsd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser
);

	// A stalled output word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// The input side is open whenever the output register is free or draining.
	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with a free output register");

	// An error word carries a zero pixel and a zero run.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 48'd0)
		else $error("error word with nonzero payload");

	// A normal word always has a nonzero run length and a zero pad bit.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[46:32] != 15'd0 && !m_tdata[47])
		else $error("pixel word with zero run length");

endmodule

bind palette_rle_sprite_decoder prsd_checker u_prsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/palette_rle_sprite_decoder_checker.sv =====
// Scoreboard for the sprite decoder: predicts every output word and compares it field by field.
`timescale 1ns / 1ps

module palette_rle_sprite_decoder_checker
	import prsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // pal_index[7:0], pal_color[31:8], code_byte[39:32], frame_pixels[63:40]
	input  logic [1:0]  s_tuser,   // action[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // pixel_word[31:0], run_length[46:32], zero pad [47]
	input  logic        m_tuser,   // bad_stream[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	output int          mismatches,
	output int          pending,
	output int          words_checked,
	output int          bad_words
);

	// One expected output word.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [RUN_W-1:0] run;
		logic             bad;
	} pixel_run_t;

	pixel_run_t runs_due[$];
	pixel_run_t want;

	// Shadow of the decoder state and its registers.
	logic [COLOR_W-1:0] palette [PAL_ENTRIES];
	phase_t             phase;
	logic [7:0]         held_byte;
	logic [7:0]         lits_left;
	logic               lit_alpha;
	logic [CNT_W-1:0]   used;
	logic [CNT_W-1:0]   budget;
	logic               halted;
	logic               fmt;
	logic [1:0]         layout;
	logic [COLOR_W-1:0] key;
	logic [7:0]         code_in;

	// Place color and alpha bytes in the configured output order.
	function automatic logic [PIX_W-1:0] arrange(input logic [COLOR_W-1:0] rgb,
			input logic [7:0] alpha);
		case (layout)
			LAYOUT_RGBA: return {alpha, rgb[23:16], rgb[15:8], rgb[7:0]};
			LAYOUT_BGRA: return {alpha, rgb[7:0], rgb[15:8], rgb[23:16]};
			default:     return {8'd0, rgb};
		endcase
	endfunction

	// A run or group is refused when it would take the frame past its pixel count.
	function automatic logic over_budget(input logic [RUN_W-1:0] n);
		return ({1'b0, used} + 25'(n)) > {1'b0, budget};
	endfunction

	// A bad code or an overrun gives one flagged word and stops the frame.
	task automatic flag_error();
		halted = 1'b1;
		phase = PH_CODE;
		lits_left = '0;
		runs_due.push_back('{pixel: '0, run: '0, bad: 1'b1});
	endtask

	// Transparent run in the key color; an empty run gives nothing.
	task automatic queue_run(input logic [RUN_W-1:0] n);
		phase = PH_CODE;
		if (n != 0) begin
			if (over_budget(n)) begin
				flag_error();
			end else begin
				used = used + CNT_W'(n);
				runs_due.push_back('{pixel: arrange(key, ALPHA_CLEAR), run: n, bad: 1'b0});
			end
		end
	endtask

	// Announce a group of literals; the budget is checked for the whole group up front.
	task automatic open_literals(input logic [7:0] n, input logic with_alpha);
		phase = PH_CODE;
		if (n != 0) begin
			if (over_budget(RUN_W'(n))) begin
				flag_error();
			end else begin
				lits_left = n;
				lit_alpha = with_alpha;
				phase = PH_LIT;
			end
		end
	endtask

	// One literal pixel looked up in the palette.
	task automatic draw_literal(input logic [7:0] idx, input logic [7:0] alpha);
		used = used + 1'b1;
		lits_left = lits_left - 1'b1;
		phase = (lits_left == 0) ? PH_CODE : PH_LIT;
		runs_due.push_back('{pixel: arrange(palette[idx], alpha), run: RUN_W'(1), bad: 1'b0});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAL_ENTRIES; i++) palette[i] = '0;
			phase = PH_CODE;
			held_byte = '0;
			lits_left = '0;
			lit_alpha = 1'b0;
			used = '0;
			budget = '0;
			halted = 1'b0;
			fmt = 1'b0;
			layout = LAYOUT_RGB;
			key = '0;
			runs_due.delete();
			mismatches = 0;
			words_checked = 0;
			bad_words = 0;
		end else begin
			// Compare the word leaving the block with the oldest expectation.
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (m_tuser) bad_words++;
				if (runs_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected output word: pixel %h run %0d bad %b",
						$time, m_tdata[31:0], m_tdata[46:32], m_tuser);
				end else begin
					want = runs_due.pop_front();
					if (m_tdata[31:0] !== want.pixel) begin
						mismatches++;
						$display("%0t: pixel_word expected %h, got %h",
							$time, want.pixel, m_tdata[31:0]);
					end
					if (m_tdata[46:32] !== want.run) begin
						mismatches++;
						$display("%0t: run_length expected %0d, got %0d",
							$time, want.run, m_tdata[46:32]);
					end
					if (m_tuser !== want.bad) begin
						mismatches++;
						$display("%0t: bad_stream expected %b, got %b",
							$time, want.bad, m_tuser);
					end
				end
			end

			// Register writes.
			if (cfg_we) begin
				case (cfg_index)
					CFG_DECODE_FORMAT: fmt = cfg_wdata[0];
					CFG_PIXEL_LAYOUT:  layout = cfg_wdata[1:0];
					CFG_KEY_COLOR:     key = cfg_wdata;
					default: ;
				endcase
			end

			// Advance the shadow parser on each accepted input word.
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					ACT_PAL_WRITE: palette[s_tdata[7:0]] = s_tdata[31:8];
					ACT_FRAME: begin
						budget = s_tdata[63:40];
						used = '0;
						phase = PH_CODE;
						held_byte = '0;
						lits_left = '0;
						lit_alpha = 1'b0;
						halted = 1'b0;
					end
					ACT_DATA: begin
						code_in = s_tdata[39:32];
						if (!halted) begin
							if (phase == PH_LIT) begin
								if (lit_alpha) begin
									held_byte = code_in;
									phase = PH_INDEX;
								end else begin
									draw_literal(code_in, ALPHA_OPAQUE);
								end
							end else if (phase == PH_INDEX) begin
								draw_literal(code_in, held_byte);
							end else if (!fmt) begin
								// Byte codes: above the run base is a run, else a literal count.
								if (code_in > RUN_BASE) queue_run(RUN_W'(code_in - RUN_BASE));
								else open_literals(code_in, 1'b0);
							end else if (phase == PH_CODE) begin
								held_byte = code_in;
								phase = PH_HIGH;
							end else if (code_in >= RUN_BASE) begin
								queue_run({code_in[6:0], held_byte});
							end else if (code_in == HIGH_ALPHA) begin
								open_literals(held_byte, 1'b1);
							end else if (code_in == HIGH_PLAIN) begin
								open_literals(held_byte, 1'b0);
							end else begin
								flag_error();
							end
						end
					end
					default: ;
				endcase
			end
		end
		pending = runs_due.size();
	end

endmodule

// ===== dv/palette_rle_sprite_decoder_test.sv =====
// Testbench top for the sprite decoder: clock, reset, stimulus, stream pacing and verdict.
`timescale 1ns / 1ps

module palette_rle_sprite_decoder_test;
	import prsd_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 850;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_wdata;

	int mismatches;
	int pending;
	int words_checked;
	int bad_words;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int words_sent = 0;
	logic cur_fmt = 1'b0;

	palette_rle_sprite_decoder u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	palette_rle_sprite_decoder_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .pending(pending),
		.words_checked(words_checked), .bad_words(bad_words)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side: stall at random according to the current pacing.
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= rx_stall_pct);
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("Timed out with %0d output words still expected.", pending);
		$display("palette_rle_sprite_decoder_test: errors");
		$finish;
	end

	// Offer one input word, with random idle cycles ahead of it, and wait for the handshake.
	task automatic send_word(input logic [1:0] act, input logic [7:0] idx,
			input logic [23:0] color, input logic [7:0] code, input logic [23:0] frame);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = {frame, code, color, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act != ACT_UNUSED) words_sent++;
	endtask

	// Unused fields of each word carry random values.
	task automatic pal_write(input logic [7:0] idx, input logic [23:0] color);
		send_word(ACT_PAL_WRITE, idx, color, 8'($urandom), 24'($urandom));
	endtask

	task automatic frame_start(input logic [23:0] pixels);
		send_word(ACT_FRAME, 8'($urandom), 24'($urandom), 8'($urandom), pixels);
	endtask

	task automatic put_byte(input logic [7:0] code);
		send_word(ACT_DATA, 8'($urandom), 24'($urandom), code, 24'($urandom));
	endtask

	// Literal payload: index bytes, or alpha and index pairs.
	task automatic send_indexes(input int n, input logic pairs);
		for (int k = 0; k < n; k++) begin
			if (pairs) put_byte(8'($urandom));
			put_byte(8'($urandom));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Drain the block, let words without a result clear the pipeline, then write all registers.
	task automatic reconfigure(input logic fmt, input logic [1:0] layout,
			input logic [23:0] key);
		@(negedge clk);
		s_tvalid = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		write_reg(CFG_DECODE_FORMAT, 24'(fmt));
		write_reg(CFG_PIXEL_LAYOUT, 24'(layout));
		write_reg(CFG_KEY_COLOR, key);
		cur_fmt = fmt;
	endtask

	// One frame of mostly well-formed codes with random content, plus some noise.
	task automatic random_frame();
		int segs;
		int pick;
		int n;
		int sent;
		logic [7:0] hi;
		repeat ($urandom_range(3)) pal_write(8'($urandom), 24'($urandom));
		pick = $urandom_range(99);
		if (pick < 15) frame_start(24'($urandom));
		else if (pick < 30) frame_start(24'($urandom_range(12)));
		else frame_start(24'($urandom_range(40, 600)));
		segs = $urandom_range(2, 9);
		for (int s = 0; s < segs; s++) begin
			pick = $urandom_range(99);
			n = $urandom_range(1, 6);
			if ($urandom_range(99) < 3) n = 0;
			sent = ($urandom_range(99) < 5) ? $urandom_range(n) : n;
			if (pick < 5) begin
				// Noise: an unused action or a stray data byte.
				if ($urandom_range(1)) begin
					send_word(ACT_UNUSED, 8'($urandom), 24'($urandom), 8'($urandom),
						24'($urandom));
				end else begin
					put_byte(8'($urandom));
				end
			end else if (!cur_fmt) begin
				if (pick < 45) begin
					put_byte(8'($urandom_range(8'h81, 8'hFF)));
				end else begin
					if ($urandom_range(99) < 2) begin
						n = RUN_BASE;
						sent = n;
					end
					put_byte(8'(n));
					send_indexes(sent, 1'b0);
				end
			end else begin
				if (pick < 40) begin
					// Runs mostly short; now and then with a random high byte.
					put_byte(8'($urandom));
					if (pick < 30) put_byte(RUN_BASE);
					else put_byte(RUN_BASE | 8'($urandom_range(127)));
				end else if (pick < 92) begin
					if ($urandom_range(99) < 1) begin
						n = 255;
						sent = n;
					end
					put_byte(8'(n));
					put_byte((pick < 66) ? HIGH_ALPHA : HIGH_PLAIN);
					send_indexes(sent, pick < 66);
				end else begin
					// Illegal high byte.
					do hi = 8'($urandom_range(1, 127)); while (hi == HIGH_ALPHA);
					put_byte(8'($urandom));
					put_byte(hi);
				end
			end
		end
	endtask

	initial begin
		int p;
		int base;
		int phase_end;
		int wait_cycles;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_PAL_WRITE;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DECODE_FORMAT;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Byte codes: data before any frame, code extremes, empty group, overrun.
		reconfigure(1'b0, LAYOUT_RGBA, 24'hFFFFFF);
		put_byte(8'h81);
		put_byte(8'h03);
		pal_write(8'h00, 24'hFFFFFF);
		pal_write(8'hFF, 24'hA5C30F);
		frame_start(24'hFFFFFF);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h02);
		put_byte(8'h00);
		put_byte(8'hFF);
		send_word(ACT_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF);
		frame_start(24'd5);
		put_byte(8'h86);
		put_byte(8'h81);

		// Word codes: longest run, empty run, both literal kinds, illegal high byte.
		reconfigure(1'b1, LAYOUT_BGRA, 24'h000000);
		frame_start(24'hFFFFFF);
		put_byte(8'hFF);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(RUN_BASE);
		put_byte(8'h02);
		put_byte(HIGH_ALPHA);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h01);
		put_byte(HIGH_PLAIN);
		put_byte(8'hFF);
		put_byte(8'h05);
		put_byte(8'h41);

		// Random phases, each with its own settings and pacing.
		base = words_sent;
		p = 0;
		while (words_sent - base < RANDOM_WORDS) begin
			reconfigure((p < 2) ? 1'(p) : 1'($urandom_range(1)),
				(p < 4) ? 2'(p) : 2'($urandom_range(3)),
				(p == 0) ? 24'h000000 : (p == 1) ? 24'hFFFFFF : 24'($urandom));
			case (p % 4)
				1: tx_idle_pct = 61;
				2: rx_stall_pct = 61;
				3: begin
					tx_idle_pct = 24;
					rx_stall_pct = 24;
				end
				default: ;
			endcase
			phase_end = words_sent + $urandom_range(70, 130);
			while (words_sent < phase_end) random_frame();
			p++;
		end

		// Drain what is still in flight.
		@(negedge clk);
		s_tvalid = 1'b0;
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (8) @(negedge clk);

		$display("Sent %0d input words over %0d register settings, with idle and stall pacing.",
			words_sent, p + 2);
		$display("Checked %0d output words (%0d bad-stream), %0d never arrived, %0d mismatches.",
			words_checked, bad_words, pending, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("palette_rle_sprite_decoder_test: clean");
		end else begin
			$display("palette_rle_sprite_decoder_test: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/prsd_pkg.sv
sv/prsd_ram.sv
sv/prsd_palette.sv
sv/prsd_parser.sv
sv/palette_rle_sprite_decoder.sv
sv/prsd_checker.sv
dv/palette_rle_sprite_decoder_checker.sv
dv/palette_rle_sprite_decoder_test.sv
